// ===== rtl/trrw_pkg.sv =====
// Shared types and constants of the trace record ring writer.
package trrw_pkg;

	localparam int STORE_BYTES  = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = $clog2(STORE_BYTES);
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
	localparam int LEN_W        = 13;
	localparam int LEVEL_W      = 16;
	localparam int BYTE_W       = 8;
	localparam int SUM_W        = 16;
	localparam int USABLE_RESET = 4096;

	typedef enum logic [1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_READ    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TOO_LONG   = 2'd1,
		ST_UNEXPECTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEADER,
		S_READ
	} state_t;

	typedef struct packed {
		logic                 accept_begin;
		logic                 accept_payload;
		logic                 accept_read;
		logic                 load_result;
		logic                 load_read;
		logic                 hdr_write;
		logic [HDR_IDX_W-1:0] hdr_index;
	} ctl_cmd_t;

	typedef struct packed {
		logic begin_fits;
	} dp_status_t;

endpackage

// ===== rtl/trrw_ram.sv =====
// Generic single-port RAM with registered read data.
module trrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/trrw_ctrl.sv =====
// Controller of the trace record ring writer: handshakes, header sequencing, read wait.
module trrw_ctrl import trrw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t dp_status,
	output ctl_cmd_t   cmd,
	output state_t     state
);

	state_t               state_q;
	state_t               state_next;
	logic [HDR_IDX_W-1:0] hdr_idx_q;
	logic                 out_valid_q;
	logic                 accept;
	cmd_t                 op;

	assign op       = cmd_t'(command);
	// A new item may enter while the waiting result leaves in the same cycle.
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == CMD_BEGIN && dp_status.begin_fits) begin
					state_next = S_HEADER;
				end else if (accept && op == CMD_READ) begin
					state_next = S_READ;
				end
			end
			S_HEADER: begin
				if (hdr_idx_q == {HDR_IDX_W{1'b1}}) begin
					state_next = S_IDLE;
				end
			end
			S_READ: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd                = '0;
		cmd.accept_begin   = accept && op == CMD_BEGIN;
		cmd.accept_payload = accept && op == CMD_PAYLOAD;
		cmd.accept_read    = accept && op == CMD_READ;
		cmd.load_result    = accept && op != CMD_READ;
		cmd.load_read      = state_q == S_READ;
		cmd.hdr_write      = state_q == S_HEADER;
		cmd.hdr_index      = hdr_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hdr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == S_HEADER) begin
				hdr_idx_q <= hdr_idx_q + 1'b1;
			end
			if (cmd.load_result || cmd.load_read) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

// ===== rtl/trrw_dpath.sv =====
// Datapath of the trace record ring writer: placement, record state, store and result register.
module trrw_dpath import trrw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           cmd,
	output dp_status_t         dp_status,
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_wdata,
	input  logic [1:0]         command,
	input  logic [LEN_W-1:0]   label_len,
	input  logic [LEN_W-1:0]   data_len,
	input  logic [LEVEL_W-1:0] log_level,
	input  logic               binary_flag,
	input  logic [BYTE_W-1:0]  payload_byte,
	input  logic [ADDR_W-1:0]  read_address,
	output logic [1:0]         status,
	output logic [ADDR_W-1:0]  record_offset,
	output logic               has_previous,
	output logic [ADDR_W-1:0]  previous_offset,
	output logic [BYTE_W-1:0]  read_byte
);

	// Configuration and record state.
	logic [LEN_W-1:0]   usable_q;
	logic               empty_q;
	logic [ADDR_W-1:0]  newest_off_q;
	logic [LEN_W-1:0]   newest_len_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [LEN_W-1:0]   remaining_q;

	// Header fields held while the header bytes go out.
	logic [ADDR_W-1:0]  hdr_base_q;
	logic               hdr_nolink_q;
	logic [ADDR_W-1:0]  hdr_link_q;
	logic [LEN_W-1:0]   hdr_label_q;
	logic [LEN_W-1:0]   hdr_data_q;
	logic [LEVEL_W-1:0] hdr_level_q;
	logic               hdr_binary_q;

	// Result register.
	logic [1:0]         status_q;
	logic [ADDR_W-1:0]  offset_q;
	logic               has_prev_q;
	logic [ADDR_W-1:0]  prev_q;
	logic [BYTE_W-1:0]  rbyte_q;

	logic [LEN_W-1:0]   limit;
	logic [SUM_W-1:0]   rec_len;
	logic [SUM_W-1:0]   append;
	logic               wraps;
	logic               fits;
	logic [ADDR_W-1:0]  place;
	logic               pay_ok;
	logic [BYTE_W-1:0]  hdr_byte;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [BYTE_W-1:0]  ram_wdata;
	logic [BYTE_W-1:0]  ram_rdata;
	cmd_t               op;

	assign op = cmd_t'(command);

	always_comb begin
		limit   = (usable_q > LEN_W'(STORE_BYTES)) ? LEN_W'(STORE_BYTES) : usable_q;
		rec_len = SUM_W'(HEADER_BYTES) + SUM_W'(label_len) + SUM_W'(data_len);
		fits    = rec_len <= SUM_W'(limit);
		append  = SUM_W'(newest_off_q) + SUM_W'(newest_len_q);
		wraps   = (append + rec_len) > SUM_W'(limit);
		place   = (empty_q || wraps) ? '0 : append[ADDR_W-1:0];
		pay_ok  = remaining_q != '0;
	end

	assign dp_status.begin_fits = fits;

	// Little-endian header: link, label length, data length, level, flags.
	always_comb begin
		unique case (cmd.hdr_index)
			4'd0:    hdr_byte = hdr_nolink_q ? 8'hff : hdr_link_q[7:0];
			4'd1:    hdr_byte = hdr_nolink_q ? 8'hff : BYTE_W'(hdr_link_q[ADDR_W-1:8]);
			4'd2:    hdr_byte = hdr_nolink_q ? 8'hff : 8'h00;
			4'd3:    hdr_byte = hdr_nolink_q ? 8'hff : 8'h00;
			4'd4:    hdr_byte = hdr_label_q[7:0];
			4'd5:    hdr_byte = BYTE_W'(hdr_label_q[LEN_W-1:8]);
			4'd8:    hdr_byte = hdr_data_q[7:0];
			4'd9:    hdr_byte = BYTE_W'(hdr_data_q[LEN_W-1:8]);
			4'd12:   hdr_byte = hdr_level_q[7:0];
			4'd13:   hdr_byte = hdr_level_q[15:8];
			4'd14:   hdr_byte = BYTE_W'(hdr_binary_q);
			default: hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = read_address;
		ram_wdata = payload_byte;
		priority if (cmd.hdr_write) begin
			ram_we    = 1'b1;
			ram_addr  = hdr_base_q + ADDR_W'(cmd.hdr_index);
			ram_wdata = hdr_byte;
		end else if (cmd.accept_payload) begin
			ram_we   = pay_ok;
			ram_addr = ptr_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	trrw_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q     <= LEN_W'(USABLE_RESET);
			empty_q      <= 1'b1;
			newest_off_q <= '0;
			newest_len_q <= '0;
			ptr_q        <= '0;
			remaining_q  <= '0;
		end else begin
			if (cfg_we) begin
				usable_q <= cfg_wdata;
			end
			if (cmd.accept_begin && fits) begin
				empty_q      <= 1'b0;
				newest_off_q <= place;
				newest_len_q <= rec_len[LEN_W-1:0];
				ptr_q        <= place + ADDR_W'(HEADER_BYTES);
				remaining_q  <= label_len + data_len;
			end else if (cmd.accept_payload && pay_ok) begin
				ptr_q       <= ptr_q + 1'b1;
				remaining_q <= remaining_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_begin && fits) begin
			hdr_base_q   <= place;
			hdr_nolink_q <= empty_q;
			hdr_link_q   <= newest_off_q;
			hdr_label_q  <= label_len;
			hdr_data_q   <= data_len;
			hdr_level_q  <= log_level;
			hdr_binary_q <= binary_flag;
		end
		if (cmd.load_result) begin
			status_q   <= ST_OK;
			offset_q   <= newest_off_q;
			has_prev_q <= 1'b0;
			prev_q     <= '0;
			rbyte_q    <= '0;
			if (op == CMD_BEGIN) begin
				if (fits) begin
					offset_q   <= place;
					has_prev_q <= !empty_q;
					prev_q     <= empty_q ? '0 : newest_off_q;
				end else begin
					status_q <= ST_TOO_LONG;
				end
			end else if (op == CMD_PAYLOAD && !pay_ok) begin
				status_q <= ST_UNEXPECTED;
			end
		end else if (cmd.load_read) begin
			status_q   <= ST_OK;
			offset_q   <= newest_off_q;
			has_prev_q <= 1'b0;
			prev_q     <= '0;
			rbyte_q    <= ram_rdata;
		end
	end

	assign status          = status_q;
	assign record_offset   = offset_q;
	assign has_previous    = has_prev_q;
	assign previous_offset = prev_q;
	assign read_byte       = rbyte_q;

endmodule

// ===== rtl/trace_record_ring_writer_core.sv =====
// Top level of the trace record ring writer: controller, datapath and checks.
// Stores variable-length trace records in a 4096-byte store with one write/read port.
// Payload beats, rejected begins and unknown commands enter no wait state, so payload
// bytes stream at one per cycle unless a waiting result is stalled. A read passes
// through S_READ, as the store has a registered read port. A begin that fits is
// answered at once, then the 16 header bytes go through the single store write port,
// one per cycle, during which no input is taken. A result waiting in the output
// register does not hold off the next beat as long as it leaves in that cycle. The
// store is not cleared after reset; reading a byte never written returns garbage.
module trace_record_ring_writer_core import trrw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [LEN_W-1:0]   label_len,
	input  logic [LEN_W-1:0]   data_len,
	input  logic [LEVEL_W-1:0] log_level,
	input  logic               binary_flag,
	input  logic [BYTE_W-1:0]  payload_byte,
	input  logic [ADDR_W-1:0]  read_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [ADDR_W-1:0]  record_offset,
	output logic               has_previous,
	output logic [ADDR_W-1:0]  previous_offset,
	output logic [BYTE_W-1:0]  read_byte
);

	ctl_cmd_t   cmd;
	dp_status_t dp_status;
	state_t     state;

	trrw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_status (dp_status),
		.cmd       (cmd),
		.state     (state)
	);

	trrw_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.dp_status       (dp_status),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.command         (command),
		.label_len       (label_len),
		.data_len        (data_len),
		.log_level       (log_level),
		.binary_flag     (binary_flag),
		.payload_byte    (payload_byte),
		.read_address    (read_address),
		.status          (status),
		.record_offset   (record_offset),
		.has_previous    (has_previous),
		.previous_offset (previous_offset),
		.read_byte       (read_byte)
	);

	// Header writes own the store port, so no beat may enter meanwhile.
	a_no_accept_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		state == S_HEADER |-> !(in_valid && !in_stall))
		else $error("input beat taken during header write");

	// Every non-read beat is answered in the next cycle.
	a_direct_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command != CMD_READ) |=> out_valid)
		else $error("missing result after beat");

	// A read is answered once its S_READ state has passed, with no result shown during it.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == CMD_READ) |=> !out_valid ##1 out_valid)
		else $error("read result out of place");

	// A header burst always runs to its last byte before the block is idle again.
	a_header_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_HEADER && cmd.hdr_index != {HDR_IDX_W{1'b1}}) |=> state == S_HEADER)
		else $error("header burst cut short");

endmodule
